@@ rtl/tlpmq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpmq_pkg
// Shared widths, status codes and control types for the two-level priority
// message queue.
// ----------------------------------------------------------------------------
package tlpmq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH  = 16;
	localparam int DEFAULT_PAYLOAD_BITS = 64;

	localparam int SENDER_W = 22;
	localparam int KIND_W   = 8;
	localparam int BODY_W   = 64;
	localparam int COUNT_W  = 6;

	localparam logic [KIND_W-1:0] THRESHOLD_RESET = 8'd5;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 6'd63;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_SENDER = 2'd1,
		ST_FULL       = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	typedef enum logic {
		REQ_SEND    = 1'b0,
		REQ_RECEIVE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_BUSY = 2'b10
	} ctl_state_t;

	// push/pop strobes handed to one queue store
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

endpackage

@@ rtl/tlpmq_fifo.sv @@
// ----------------------------------------------------------------------------
// tlpmq_fifo
// One message class: entry memory with registered read, head/tail pointers
// and fill count.
// ----------------------------------------------------------------------------
module tlpmq_fifo #(
	parameter int QUEUE_DEPTH  = tlpmq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int PAYLOAD_BITS = tlpmq_pkg::DEFAULT_PAYLOAD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlpmq_pkg::q_ctl_t                   ctl,
	input  logic [tlpmq_pkg::SENDER_W-1:0]      wr_sender,
	input  logic [tlpmq_pkg::KIND_W-1:0]        wr_kind,
	input  logic [PAYLOAD_BITS-1:0]             wr_body,
	output logic [tlpmq_pkg::SENDER_W-1:0]      rd_sender,
	output logic [tlpmq_pkg::KIND_W-1:0]        rd_kind,
	output logic [PAYLOAD_BITS-1:0]             rd_body,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    fill
);
	import tlpmq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = SENDER_W + KIND_W + PAYLOAD_BITS;

	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [FW-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= {wr_body, wr_kind, wr_sender};
		end
		if (ctl.pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign rd_sender = rd_q[SENDER_W-1:0];
	assign rd_kind   = rd_q[SENDER_W +: KIND_W];
	assign rd_body   = rd_q[SENDER_W + KIND_W +: PAYLOAD_BITS];
	assign fill      = fill_q;

endmodule

@@ rtl/two_level_priority_message_queue.sv @@
// ----------------------------------------------------------------------------
// two_level_priority_message_queue
// Send/receive requests against a high and a normal message FIFO; receive
// prefers the high FIFO. One result word per request.
// ----------------------------------------------------------------------------
// The BUSY state entered on taking the request word loads the result and raises valid.
// Requests are taken only in IDLE: decision, pointer update and memory read, then the
// result register, before the next; a result word still held blocks new input.
// Reset: pointers and fill counts clear, threshold returns to 5; message
// memories are not cleared, entries are only read after being written.
module two_level_priority_message_queue #(
	parameter int QUEUE_DEPTH  = tlpmq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int PAYLOAD_BITS = tlpmq_pkg::DEFAULT_PAYLOAD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [7:0]    cfg_wdata,      // high_threshold
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,        // sender_id[21:0], msg_kind[29:22], payload[93:30]
	input  logic          s_tuser,        // req_type
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [103:0]  m_tdata,        // out_sender[21:0], out_kind[29:22],
	                                      // out_payload[93:30], total_count[99:94]
	output logic [2:0]    m_tuser         // status[1:0], from_high[2]
);
	import tlpmq_pkg::*;

	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	ctl_state_t          state_q;
	logic [KIND_W-1:0]   thr_q;
	logic [FW-1:0]       hi_fill, no_fill;
	q_ctl_t              hi_ctl, no_ctl;
	logic [SENDER_W-1:0] hi_sender, no_sender;
	logic [KIND_W-1:0]   hi_kind, no_kind;
	logic [PAYLOAD_BITS-1:0] hi_body, no_body;

	logic [SENDER_W-1:0] in_sender;
	logic [KIND_W-1:0]   in_kind;
	logic [BODY_W-1:0]   in_payload;
	logic                accept;
	logic                is_send, bad_sender, to_high, tgt_full;
	status_t             status_d;

	status_t             status_s1;
	logic                pop_hi_s1, pop_no_s1;

	logic                m_valid_q;
	status_t             status_q;
	logic                from_high_q;
	logic [SENDER_W-1:0] sender_q;
	logic [KIND_W-1:0]   kind_q;
	logic [BODY_W-1:0]   body_q;
	logic [COUNT_W-1:0]  count_q;

	logic [FW:0]         total_sum;
	logic [COUNT_W-1:0]  total_sat;

	assign in_sender  = s_tdata[SENDER_W-1:0];
	assign in_kind    = s_tdata[SENDER_W +: KIND_W];
	assign in_payload = s_tdata[SENDER_W + KIND_W +: BODY_W];

	assign s_tready = (state_q == S_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign is_send    = (s_tuser == REQ_SEND);
	assign bad_sender = (in_sender == '0);
	assign to_high    = (in_kind >= thr_q);
	assign tgt_full   = to_high ? (hi_fill == FW'(QUEUE_DEPTH))
	                            : (no_fill == FW'(QUEUE_DEPTH));

	always_comb begin
		hi_ctl   = '0;
		no_ctl   = '0;
		status_d = ST_OK;
		if (is_send) begin
			if (bad_sender) begin
				status_d = ST_BAD_SENDER;
			end else if (tgt_full) begin
				status_d = ST_FULL;
			end else begin
				hi_ctl.push = accept && to_high;
				no_ctl.push = accept && !to_high;
			end
		end else begin
			if (hi_fill != '0) begin
				hi_ctl.pop = accept;
			end else if (no_fill != '0) begin
				no_ctl.pop = accept;
			end else begin
				status_d = ST_EMPTY;
			end
		end
	end

	tlpmq_fifo #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_high (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hi_ctl),
		.wr_sender (in_sender),
		.wr_kind   (in_kind),
		.wr_body   (in_payload[PAYLOAD_BITS-1:0]),
		.rd_sender (hi_sender),
		.rd_kind   (hi_kind),
		.rd_body   (hi_body),
		.fill      (hi_fill)
	);

	tlpmq_fifo #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_normal (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (no_ctl),
		.wr_sender (in_sender),
		.wr_kind   (in_kind),
		.wr_body   (in_payload[PAYLOAD_BITS-1:0]),
		.rd_sender (no_sender),
		.rd_kind   (no_kind),
		.rd_body   (no_body),
		.fill      (no_fill)
	);

	// fills are already updated when the result is built
	assign total_sum = (FW + 1)'(hi_fill) + (FW + 1)'(no_fill);
	assign total_sat = (32'(total_sum) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(total_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (m_valid_q && m_tready) begin
						m_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					m_valid_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			pop_hi_s1 <= hi_ctl.pop;
			pop_no_s1 <= no_ctl.pop;
		end
		if (state_q == S_BUSY) begin
			status_q    <= status_s1;
			from_high_q <= pop_hi_s1;
			count_q     <= total_sat;
			if (pop_hi_s1) begin
				sender_q <= hi_sender;
				kind_q   <= hi_kind;
				body_q   <= BODY_W'(hi_body);
			end else if (pop_no_s1) begin
				sender_q <= no_sender;
				kind_q   <= no_kind;
				body_q   <= BODY_W'(no_body);
			end else begin
				sender_q <= '0;
				kind_q   <= '0;
				body_q   <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, count_q, body_q, kind_q, sender_q};
	assign m_tuser  = {from_high_q, status_q};

endmodule
